// ===== rtl/asms_pkg.sv =====
// Shared types and codes for the aged slot message store.
`timescale 1ns / 1ps

package asms_pkg;

    // Widest slot index or rank that any legal slot count needs (up to 64 slots).
    localparam int MAX_IDX_W = 6;
    localparam int MSG_FIELD_W = 64;

    typedef logic [MAX_IDX_W-1:0]   idx_t;
    typedef logic [MSG_FIELD_W-1:0] msg_t;

    typedef enum logic [1:0] {
        OP_VIEW   = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_SCROLL = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_OVERWRITTEN = 2'd1,
        STATUS_EMPTY       = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_CLEAR
    } cmd_kind_t;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_NONZERO,
        DEC_ABOVE
    } dec_mode_t;

    // Update broadcast to every cell in the same cycle.
    typedef struct packed {
        cmd_kind_t kind;
        dec_mode_t dec;
        idx_t      tgt;
        idx_t      rank;
        idx_t      gone;
        msg_t      msg;
    } cmd_t;

    // Search results handed from cell to cell along the chain.
    typedef struct packed {
        logic free_found;
        idx_t free_idx;
        logic zero_found;
        idx_t zero_idx;
        logic hit_found;
        idx_t hit_idx;
        msg_t hit_msg;
        logic next_found;
        idx_t next_rank;
    } carry_t;

    localparam cmd_t CMD_IDLE = '{
        kind: CMD_NONE,
        dec:  DEC_NONE,
        tgt:  '0,
        rank: '0,
        gone: '0,
        msg:  '0
    };

    localparam carry_t CARRY_SEED = '0;

endpackage

// ===== rtl/asms_cell.sv =====
// One message slot: stored message, valid flag and age rank, plus its search stage.
`timescale 1ns / 1ps

module asms_cell #(
    parameter int CELL_IDX = 0,
    parameter int RANK_W   = 3,
    parameter int MSG_W    = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  asms_pkg::idx_t    key,
    input  asms_pkg::cmd_t    cmd,
    input  asms_pkg::carry_t  carry_in,
    output asms_pkg::carry_t  carry_out
);
    import asms_pkg::*;

    logic              valid_reg, valid_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [MSG_W-1:0]  msg_reg, msg_next;
    carry_t            carry_reg, carry_next;

    idx_t rank_ext;
    idx_t my_idx;

    assign rank_ext = idx_t'(rank_reg);
    assign my_idx   = idx_t'(CELL_IDX);

    // Search stage: fold this slot into the results seen so far.
    always_comb begin
        carry_next = carry_in;
        if (!carry_in.free_found && !valid_reg) begin
            carry_next.free_found = 1'b1;
            carry_next.free_idx   = my_idx;
        end
        if (!carry_in.zero_found && (rank_ext == '0)) begin
            carry_next.zero_found = 1'b1;
            carry_next.zero_idx   = my_idx;
        end
        if (!carry_in.hit_found && valid_reg && (rank_ext == key)) begin
            carry_next.hit_found = 1'b1;
            carry_next.hit_idx   = my_idx;
            carry_next.hit_msg   = msg_t'(msg_reg);
        end
        if (valid_reg && (rank_ext > key)
                && (!carry_in.next_found || (rank_ext < carry_in.next_rank))) begin
            carry_next.next_found = 1'b1;
            carry_next.next_rank  = rank_ext;
        end
    end

    // Slot update from the broadcast command.
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        msg_next   = msg_reg;
        if ((cmd.kind == CMD_WRITE) && (cmd.tgt == my_idx)) begin
            valid_next = 1'b1;
            rank_next  = cmd.rank[RANK_W-1:0];
            msg_next   = cmd.msg[MSG_W-1:0];
        end else if ((cmd.kind == CMD_CLEAR) && (cmd.tgt == my_idx)) begin
            valid_next = 1'b0;
            rank_next  = '0;
            msg_next   = '0;
        end else begin
            case (cmd.dec)
                DEC_NONZERO: begin
                    if (valid_reg && (rank_reg != '0)) begin
                        rank_next = rank_reg - 1'b1;
                    end
                end
                DEC_ABOVE: begin
                    if (valid_reg && (rank_ext > cmd.gone)) begin
                        rank_next = rank_reg - 1'b1;
                    end
                end
                default: begin
                    rank_next = rank_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Message and search stage carry no reset.
    always_ff @(posedge aclk) begin
        msg_reg   <= msg_next;
        carry_reg <= carry_next;
    end

    assign carry_out = carry_reg;

endmodule

// ===== rtl/asms_ctrl.sv =====
// Sequencer: takes a request, waits out the search wave, issues the update and holds the result.
`timescale 1ns / 1ps

module asms_ctrl #(
    parameter int SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [63:0]       s_message_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [63:0]       m_message_out,
    output logic [2:0]        m_position_now,
    output logic [3:0]        m_count_now,
    output asms_pkg::idx_t    key,
    output asms_pkg::cmd_t    cmd,
    input  asms_pkg::carry_t  carry
);
    import asms_pkg::*;

    localparam int RANK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    state_t            state_reg, state_next;
    logic [RANK_W-1:0] step_reg, step_next;
    logic [RANK_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    opcode_t           op_reg;
    msg_t              msg_reg;

    logic              m_valid_reg, m_valid_next;
    status_t           status_reg;
    msg_t              msg_out_reg;
    logic [2:0]        pos_out_reg;
    logic [3:0]        cnt_out_reg;

    logic              load_out;
    status_t           fin_status;
    msg_t              fin_msg;
    logic [RANK_W-1:0] fin_pos;
    logic [CNT_W-1:0]  fin_cnt;
    cmd_t              fin_cmd;

    assign key = idx_t'(pos_reg);

    // Outcome of the request once the search results have reached the chain end.
    always_comb begin
        fin_status = STATUS_OK;
        fin_msg    = '0;
        fin_pos    = pos_reg;
        fin_cnt    = cnt_reg;
        fin_cmd    = CMD_IDLE;
        case (op_reg)
            OP_VIEW: begin
                if (cnt_reg == '0) begin
                    fin_status = STATUS_EMPTY;
                end else if (carry.hit_found) begin
                    fin_msg = carry.hit_msg;
                end
            end
            OP_ADD: begin
                fin_cmd.kind = CMD_WRITE;
                fin_cmd.msg  = msg_reg;
                if (carry.free_found) begin
                    fin_cnt     = cnt_reg + 1'b1;
                    fin_cmd.tgt = carry.free_idx;
                end else begin
                    fin_status  = STATUS_OVERWRITTEN;
                    fin_cmd.tgt = carry.zero_found ? carry.zero_idx : '0;
                    fin_cmd.dec = DEC_NONZERO;
                end
                fin_cmd.rank = (fin_cnt == '0) ? '0 : idx_t'(fin_cnt - 1'b1);
            end
            OP_DELETE: begin
                fin_cmd.dec = DEC_ABOVE;
                if (carry.hit_found) begin
                    fin_cmd.kind = CMD_CLEAR;
                    fin_cmd.tgt  = carry.hit_idx;
                    fin_cmd.gone = idx_t'(pos_reg);
                end
                if (cnt_reg != '0) begin
                    if (CNT_W'(pos_reg) == (cnt_reg - 1'b1)) begin
                        fin_pos = '0;
                    end
                    fin_cnt = cnt_reg - 1'b1;
                end else begin
                    fin_status = STATUS_EMPTY;
                end
            end
            OP_SCROLL: begin
                if (cnt_reg <= CNT_W'(1)) begin
                    fin_pos    = '0;
                    fin_status = STATUS_EMPTY;
                end else if (carry.next_found) begin
                    fin_pos = carry.next_rank[RANK_W-1:0];
                end else begin
                    fin_pos    = '0;
                    fin_status = STATUS_EMPTY;
                end
            end
            default: begin
                fin_status = STATUS_OK;
            end
        endcase
    end

    // Next state and handshake outputs.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        cmd          = CMD_IDLE;
        load_out     = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SEARCH;
                    step_next  = '0;
                end
            end
            ST_SEARCH: begin
                if (step_reg == RANK_W'(SLOTS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    cmd        = fin_cmd;
                    pos_next   = fin_pos;
                    cnt_next   = fin_cnt;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= opcode_t'(s_opcode);
            msg_reg <= s_message_in;
        end
        if (load_out) begin
            status_reg  <= fin_status;
            msg_out_reg <= fin_msg;
            pos_out_reg <= 3'(fin_pos);
            cnt_out_reg <= 4'(fin_cnt);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_message_out  = msg_out_reg;
    assign m_position_now = pos_out_reg;
    assign m_count_now    = cnt_out_reg;

    // The message count never exceeds the number of slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("message count above slot count");

    // An accepted request starts the search wave from its first step.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SEARCH) && (step_reg == '0))
        else $error("accepted request did not start the search");

    // A slot update is only issued together with a result transfer being loaded.
    a_cmd_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.kind != CMD_NONE) |=> m_valid)
        else $error("slot update without a result");

    // A delete on an empty store leaves the count at zero.
    a_delete_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && (op_reg == OP_DELETE) && (cnt_reg == '0)) |=> (cnt_reg == '0))
        else $error("delete on empty store changed the count");

    // A scroll that reports empty or wrapped leaves the position at zero.
    a_scroll_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && (op_reg == OP_SCROLL) && (fin_status == STATUS_EMPTY))
            |=> (pos_reg == '0))
        else $error("wrapped scroll left a nonzero position");

endmodule

// ===== rtl/aged_slot_message_store.sv =====
// Top level of the aged slot message store: a chain of slot cells and its sequencer.
// A request passes the search and finish states before its result is registered.
// Requests are taken one at a time; the search wave walks the slot cell chain one
// cell per cycle before the update is applied, which waits on an unaccepted result.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (aresetn low at a clock edge) empties every slot and zeroes position and count.
`timescale 1ns / 1ps

module aged_slot_message_store #(
    parameter int SLOTS         = 8,
    parameter int MESSAGE_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_message_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_message_out,
    output logic [2:0]  m_position_now,
    output logic [3:0]  m_count_now
);
    import asms_pkg::*;

    localparam int RANK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MSG_W  = 8 * MESSAGE_BYTES;

    idx_t   key;
    cmd_t   cmd;
    carry_t chain [SLOTS+1];

    // Search wave enters the first cell with nothing found.
    assign chain[0] = CARRY_SEED;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        asms_cell #(
            .CELL_IDX (i),
            .RANK_W   (RANK_W),
            .MSG_W    (MSG_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key       (key),
            .cmd       (cmd),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1])
        );
    end

    asms_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_message_in   (s_message_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_message_out  (m_message_out),
        .m_position_now (m_position_now),
        .m_count_now    (m_count_now),
        .key            (key),
        .cmd            (cmd),
        .carry          (chain[SLOTS])
    );

endmodule
